// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Timer slot task scheduler assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
// All three macros sample on the rising clock edge and are quiet while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge.
`define TSTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TSTS_ASSERT_IMP(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define TSTS_ASSERT_NXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tsts_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer slot task scheduler package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tsts_pkg;

  localparam int SLOTS       = 5;
  localparam int PARAM_LIMIT = 32;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int KIND_W   = 2;
  localparam int TAG_W    = 8;
  localparam int DELAY_W  = 16;
  localparam int LEN_W    = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_DISP  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_NO_SLOT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_READY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DISP
  } fsm_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic sched;
    logic tick;
    logic disp;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              out_free;
    logic              any_ready;
  } dp_sts_t;

  // lowest set bit of a slot mask
  function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/tsts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Timer slot task scheduler controller
// Sequences accept, execute and the dispatch walk.
// ----------------------------------------------------------------------------
module tsts_ctrl import tsts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        unique case (sts_i.kind)
          KIND_SCHED: begin
            if (sts_i.out_free) begin
              cmd_o.sched = 1'b1;
              state_d     = FSM_IDLE;
            end
          end
          KIND_TICK: begin
            cmd_o.tick = 1'b1;
            state_d    = FSM_IDLE;
          end
          KIND_DISP: state_d = FSM_DISP;
          default:   state_d = FSM_IDLE;  // unused kind: dropped
        endcase
      end
      FSM_DISP: begin
        if (!sts_i.any_ready) begin
          state_d = FSM_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.disp = 1'b1;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

endmodule

// ----- rtl/tsts_dpath.sv -----
// ----------------------------------------------------------------------------
// Timer slot task scheduler datapath
// Item register, slot pool and result register.
// ----------------------------------------------------------------------------
module tsts_dpath import tsts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_sts_t             sts_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [TAG_W-1:0]    task_tag_i,
  input  logic [DELAY_W-1:0]  delay_ticks_i,
  input  logic                repeat_task_i,
  input  logic [LEN_W-1:0]    param_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                is_dispatch_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [TAG_W-1:0]    run_tag_o,
  output logic                last_of_run_o
);

  // item register
  logic [KIND_W-1:0]  kind_q;
  logic [TAG_W-1:0]   itag_q;
  logic [DELAY_W-1:0] idelay_q;
  logic               irep_q;
  logic               too_long_q;

  // slot pool
  mode_e              mode_q   [SLOTS];
  mode_e              mode_d   [SLOTS];
  logic [TAG_W-1:0]   stag_q   [SLOTS];
  logic               srep_q   [SLOTS];
  logic [DELAY_W-1:0] target_q [SLOTS];
  logic [DELAY_W-1:0] count_q  [SLOTS];
  logic [DELAY_W-1:0] count_d  [SLOTS];
  logic [DELAY_W-1:0] count_inc[SLOTS];

  // result register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] r_status_q, r_status_d;
  logic                r_disp_q, r_disp_d;
  logic [IDX_W-1:0]    r_idx_q, r_idx_d;
  logic [TAG_W-1:0]    r_tag_q, r_tag_d;
  logic                r_last_q, r_last_d;

  logic [SLOTS-1:0] idle_mask, ready_mask, ready_rest, sel_oh;
  logic [IDX_W-1:0] free_idx, rdy_idx;
  logic             sched_ok;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      idle_mask[i]  = (mode_q[i] == MODE_IDLE);
      ready_mask[i] = (mode_q[i] == MODE_READY);
    end
  end

  assign free_idx   = first_set(idle_mask);
  assign rdy_idx    = first_set(ready_mask);
  assign sel_oh     = SLOTS'(1) << rdy_idx;
  assign ready_rest = ready_mask & ~sel_oh;
  assign sched_ok   = cmd_i.sched && !too_long_q && (idle_mask != '0);

  assign sts_o.kind      = kind_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.any_ready = (ready_mask != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q     <= kind_i;
      itag_q     <= task_tag_i;
      idelay_q   <= delay_ticks_i;
      irep_q     <= repeat_task_i;
      too_long_q <= (param_length_i > LEN_W'(PARAM_LIMIT));
    end
  end

  // per-slot next state
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      mode_d[i]    = mode_q[i];
      count_d[i]   = count_q[i];
      count_inc[i] = count_q[i] + DELAY_W'(1);
      if (cmd_i.tick && mode_q[i] == MODE_COUNT) begin
        count_d[i] = count_inc[i];
        if (count_inc[i] == target_q[i]) mode_d[i] = MODE_READY;
      end
      if (cmd_i.disp && sel_oh[i]) begin
        count_d[i] = '0;
        mode_d[i]  = srep_q[i] ? MODE_COUNT : MODE_IDLE;
      end
      if (sched_ok && free_idx == IDX_W'(i)) begin
        count_d[i] = '0;
        mode_d[i]  = (idelay_q == '0) ? MODE_READY : MODE_COUNT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) mode_q[i] <= MODE_IDLE;
    end else begin
      for (int i = 0; i < SLOTS; i++) mode_q[i] <= mode_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      count_q[i] <= count_d[i];
      if (sched_ok && free_idx == IDX_W'(i)) begin
        stag_q[i]   <= itag_q;
        srep_q[i]   <= irep_q;
        target_q[i] <= idelay_q;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    r_status_d  = r_status_q;
    r_disp_d    = r_disp_q;
    r_idx_d     = r_idx_q;
    r_tag_d     = r_tag_q;
    r_last_d    = r_last_q;
    if (cmd_i.sched) begin
      out_valid_d = 1'b1;
      r_disp_d    = 1'b0;
      r_tag_d     = '0;
      r_last_d    = 1'b1;
      if (too_long_q) begin
        r_status_d = STAT_TOO_LONG;
        r_idx_d    = '0;
      end else if (idle_mask == '0) begin
        r_status_d = STAT_NO_SLOT;
        r_idx_d    = '0;
      end else begin
        r_status_d = STAT_OK;
        r_idx_d    = free_idx;
      end
    end else if (cmd_i.disp) begin
      out_valid_d = 1'b1;
      r_status_d  = STAT_OK;
      r_disp_d    = 1'b1;
      r_idx_d     = rdy_idx;
      r_tag_d     = stag_q[rdy_idx];
      r_last_d    = (ready_rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_status_q <= r_status_d;
    r_disp_q   <= r_disp_d;
    r_idx_q    <= r_idx_d;
    r_tag_q    <= r_tag_d;
    r_last_q   <= r_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = r_status_q;
  assign is_dispatch_o = r_disp_q;
  assign slot_index_o  = SLOT_W'(r_idx_q);
  assign run_tag_o     = r_tag_q;
  assign last_of_run_o = r_last_q;

endmodule

// ----- rtl/timer_slot_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Timer slot task scheduler
// Pool of one-shot and periodic timer slots with schedule, tick and dispatch.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid_i/in_ready_o | kind, task_tag, delay_ticks,
//          |           |                       | repeat_task, param_length
//  out     | output    | out_valid_o/out_ready_i | status, is_dispatch, slot_index,
//          |           |                       | run_tag, last_of_run
//
//  Sequence: schedule and tick are accepted, then executed; a dispatch is
//  accepted, executed, then emits one result per cycle while the output is free,
//  with the controller walking the ready mask through a single result register.
//  Reset: rst_ni clears the controller, all slot modes (idle) and result valid.
//  Stalls: a held result blocks the next schedule or dispatch result only;
//  the item side stays closed until the current transaction has finished.
// ----------------------------------------------------------------------------
module timer_slot_task_scheduler_unit import tsts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [TAG_W-1:0]    task_tag_i,
  input  logic [DELAY_W-1:0]  delay_ticks_i,
  input  logic                repeat_task_i,
  input  logic [LEN_W-1:0]    param_length_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                is_dispatch_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [TAG_W-1:0]    run_tag_o,
  output logic                last_of_run_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Controller: waits for an item, then runs its kind. Dispatch loops, one
  // ready slot per cycle while the output is free, until the ready mask is empty.
  tsts_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // Datapath: captures the item, holds the slots, counts ticks, picks the
  // lowest idle slot for a schedule and the lowest ready slot for a dispatch.
  tsts_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .kind_i,
    .task_tag_i,
    .delay_ticks_i,
    .repeat_task_i,
    .param_length_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .is_dispatch_o,
    .slot_index_o,
    .run_tag_o,
    .last_of_run_o
  );

endmodule

// ----- rtl/tsts_chk.sv -----
// ----------------------------------------------------------------------------
// Timer slot task scheduler checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsts_chk import tsts_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic                is_dispatch_i,
  input logic [SLOT_W-1:0]   slot_index_i,
  input logic [TAG_W-1:0]    run_tag_i,
  input logic                last_of_run_i
);

  `TSTS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `TSTS_ASSERT_IMP(a_sched_shape, clk_i, rst_ni, out_valid_i && !is_dispatch_i, last_of_run_i && run_tag_i == '0, "schedule result malformed")
  `TSTS_ASSERT_IMP(a_disp_ok, clk_i, rst_ni, out_valid_i && is_dispatch_i, status_i == STAT_OK, "dispatch result with error status")
  `TSTS_ASSERT_IMP(a_err_slot, clk_i, rst_ni, out_valid_i && status_i != STAT_OK, slot_index_i == '0 && !is_dispatch_i, "error result names a slot")
  `TSTS_ASSERT_IMP(a_slot_range, clk_i, rst_ni, out_valid_i, slot_index_i < SLOT_W'(SLOTS), "slot index out of range")

endmodule

bind timer_slot_task_scheduler_unit tsts_chk u_tsts_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_i      (status_o),
  .is_dispatch_i (is_dispatch_o),
  .slot_index_i  (slot_index_o),
  .run_tag_i     (run_tag_o),
  .last_of_run_i (last_of_run_o)
);
